@@ hdl/websocket_frame_deframer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// websocket deframer assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is asserted
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define WSFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsfd same-cycle check failed");

// next-cycle implication
`define WSFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsfd next-cycle check failed");

`endif

@@ hdl/wsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsfd_pkg
// types and constants shared by the websocket frame deframer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsfd_pkg;

    localparam int BYTE_W = 8;
    localparam int OPC_W  = 4;
    localparam int LEN_W  = 64;
    localparam int KEY_W  = 32;
    localparam int LEN7_W = 7;

    localparam logic [LEN7_W-1:0] LEN_EXT16 = 7'd126;
    localparam logic [LEN7_W-1:0] LEN_EXT64 = 7'd127;

    // extended-length or key bytes still to come, minus one
    localparam logic [2:0] EXT16_CNT = 3'd1;
    localparam logic [2:0] EXT64_CNT = 3'd7;
    localparam logic [2:0] KEY_CNT   = 3'd3;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASKKEY = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [OPC_W-1:0]  frame_opcode;
        logic              final_flag;
        logic [LEN_W-1:0]  frame_length;
        logic              empty_frame;
        logic              last_of_frame;
    } t_result;

endpackage

@@ hdl/wsfd_parse.sv @@
// ----------------------------------------------------------------------------
// wsfd_parse
// frame header parser and payload unmasking, one byte per enabled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfd_parse (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [wsfd_pkg::BYTE_W-1:0]    i_byte,
    output logic                           o_res_vld,
    output wsfd_pkg::t_result              o_res
);
    import wsfd_pkg::*;

`include "websocket_frame_deframer_unit_assert.svh"

    t_phase              r_phase,       n_phase;
    logic [2:0]          r_ext_cnt,     n_ext_cnt;
    logic [OPC_W-1:0]    r_opcode,      n_opcode;
    logic                r_final,       n_final;
    logic                r_masked,      n_masked;
    logic [KEY_W-1:0]    r_mask_key,    n_mask_key;
    logic [LEN_W-1:0]    r_payload_len, n_payload_len;
    logic [LEN_W-1:0]    r_bytes_left,  n_bytes_left;
    logic [1:0]          r_key_idx,     n_key_idx;

    logic [LEN7_W-1:0]   w_len7;
    logic                w_len_ext;
    logic [LEN_W-1:0]    w_ext_len;
    logic [LEN_W-1:0]    w_bytes_dec;
    logic [BYTE_W-1:0]   w_key;
    logic                w_res_vld;

    assign w_len7      = i_byte[LEN7_W-1:0];
    assign w_len_ext   = (w_len7 == LEN_EXT16) || (w_len7 == LEN_EXT64);
    assign w_ext_len   = {r_payload_len[LEN_W-BYTE_W-1:0], i_byte};
    assign w_bytes_dec = r_bytes_left - LEN_W'(1);

    // key byte 0 sits in the top byte of the key register
    always_comb begin
        unique case (r_key_idx)
            2'd0:    w_key = r_mask_key[31:24];
            2'd1:    w_key = r_mask_key[23:16];
            2'd2:    w_key = r_mask_key[15:8];
            default: w_key = r_mask_key[7:0];
        endcase
        if (!r_masked) begin
            w_key = '0;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HDR2: begin
                if (w_len_ext) begin
                    n_phase = PH_EXTLEN;
                end else if (i_byte[7]) begin
                    n_phase = PH_MASKKEY;
                end else if (w_len7 == '0) begin
                    n_phase = PH_HDR1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_EXTLEN: begin
                if (r_ext_cnt != '0) begin
                    n_phase = PH_EXTLEN;
                end else if (r_masked) begin
                    n_phase = PH_MASKKEY;
                end else if (w_ext_len == '0) begin
                    n_phase = PH_HDR1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_MASKKEY: begin
                if (r_ext_cnt != '0) begin
                    n_phase = PH_MASKKEY;
                end else if (r_payload_len == '0) begin
                    n_phase = PH_HDR1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_phase = (w_bytes_dec == '0) ? PH_HDR1 : PH_PAYLOAD;
            end
            default: begin
                // unused codes behave like the first header byte
                n_phase = PH_HDR2;
            end
        endcase
    end

    // datapath state and result
    always_comb begin
        n_ext_cnt     = r_ext_cnt;
        n_opcode      = r_opcode;
        n_final       = r_final;
        n_masked      = r_masked;
        n_mask_key    = r_mask_key;
        n_payload_len = r_payload_len;
        n_bytes_left  = r_bytes_left;
        n_key_idx     = r_key_idx;
        w_res_vld     = 1'b0;
        o_res.payload_byte  = '0;
        o_res.empty_frame   = 1'b0;
        o_res.last_of_frame = 1'b0;
        unique case (r_phase)
            PH_HDR2: begin
                n_masked   = i_byte[7];
                n_mask_key = '0;
                if (w_len_ext) begin
                    n_payload_len = '0;
                    n_ext_cnt     = (w_len7 == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
                end else begin
                    n_payload_len = {{(LEN_W-LEN7_W){1'b0}}, w_len7};
                    if (i_byte[7]) begin
                        n_ext_cnt = KEY_CNT;
                    end else begin
                        n_bytes_left = n_payload_len;
                        n_key_idx    = '0;
                        if (w_len7 == '0) begin
                            w_res_vld           = 1'b1;
                            o_res.empty_frame   = 1'b1;
                            o_res.last_of_frame = 1'b1;
                        end
                    end
                end
            end
            PH_EXTLEN: begin
                n_payload_len = w_ext_len;
                if (r_ext_cnt != '0) begin
                    n_ext_cnt = r_ext_cnt - 3'd1;
                end else if (r_masked) begin
                    n_ext_cnt = KEY_CNT;
                end else begin
                    n_bytes_left = w_ext_len;
                    n_key_idx    = '0;
                    if (w_ext_len == '0) begin
                        w_res_vld           = 1'b1;
                        o_res.empty_frame   = 1'b1;
                        o_res.last_of_frame = 1'b1;
                    end
                end
            end
            PH_MASKKEY: begin
                n_mask_key = {r_mask_key[KEY_W-BYTE_W-1:0], i_byte};
                if (r_ext_cnt != '0) begin
                    n_ext_cnt = r_ext_cnt - 3'd1;
                end else begin
                    n_bytes_left = r_payload_len;
                    n_key_idx    = '0;
                    if (r_payload_len == '0) begin
                        w_res_vld           = 1'b1;
                        o_res.empty_frame   = 1'b1;
                        o_res.last_of_frame = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_key_idx           = r_key_idx + 2'd1;
                n_bytes_left        = w_bytes_dec;
                w_res_vld           = 1'b1;
                o_res.payload_byte  = i_byte ^ w_key;
                o_res.last_of_frame = (w_bytes_dec == '0);
            end
            default: begin
                n_final  = i_byte[7];
                n_opcode = i_byte[OPC_W-1:0];
            end
        endcase
        o_res.frame_opcode = r_opcode;
        o_res.final_flag   = r_final;
        o_res.frame_length = n_payload_len;
    end

    assign o_res_vld = i_step && w_res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR1;
            r_ext_cnt     <= '0;
            r_opcode      <= '0;
            r_final       <= 1'b0;
            r_masked      <= 1'b0;
            r_mask_key    <= '0;
            r_payload_len <= '0;
            r_bytes_left  <= '0;
            r_key_idx     <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_ext_cnt     <= n_ext_cnt;
            r_opcode      <= n_opcode;
            r_final       <= n_final;
            r_masked      <= n_masked;
            r_mask_key    <= n_mask_key;
            r_payload_len <= n_payload_len;
            r_bytes_left  <= n_bytes_left;
            r_key_idx     <= n_key_idx;
        end
    end

    `WSFD_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, o_res_vld && o_res.last_of_frame, r_phase == PH_HDR1)
    `WSFD_ASSERT_SAME(a_payload_gives_result, i_clk, i_rst_n, i_step && (r_phase == PH_PAYLOAD), o_res_vld)
    `WSFD_ASSERT_SAME(a_empty_has_no_length, i_clk, i_rst_n, o_res_vld && o_res.empty_frame, o_res.frame_length == '0)

endmodule

@@ hdl/websocket_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// splits a received websocket byte stream into frames and unmasks payload
// ----------------------------------------------------------------------------
// input channel: one stream byte per request on i_rx_byte, taken when
//   i_valid is high and o_stall is low
// output channel: one result per request (unmasked payload byte with opcode,
//   fin, frame length, empty and last flags), taken when o_valid is high and
//   i_stall is low
// header, extended length and mask key bytes give no result; a frame with
//   zero length gives one empty-frame result on the byte ending its header
// path: a taken byte waits in the input register, its result in the result register
// throughput: one byte per cycle while i_stall is low, set by the combinational
//   parse step between the input byte register and the result register
// when the receiver stalls, the result holds; one more byte can be taken
//   into the input register, then o_stall rises until the result drains
// reset (synchronous, active low) empties both registers and puts the parser
//   at the first header byte of a new frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_deframer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [wsfd_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_stall,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wsfd_pkg::BYTE_W-1:0]         o_payload_byte,
    output logic [wsfd_pkg::OPC_W-1:0]          o_frame_opcode,
    output logic                                o_final_flag,
    output logic [wsfd_pkg::LEN_W-1:0]          o_frame_length,
    output logic                                o_empty_frame,
    output logic                                o_last_of_frame
);
    import wsfd_pkg::*;

`include "websocket_frame_deframer_unit_assert.svh"

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_result           r_out;

    logic              w_step;
    logic              w_res_vld;
    t_result           w_res;

    // byte in the input register moves on when the result slot is free
    assign w_step  = r_in_vld && !(r_out_vld && i_stall);
    assign o_stall = r_in_vld && r_out_vld && i_stall;

    wsfd_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (r_in_byte),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (!r_out_vld || !i_stall) begin
                r_out_vld <= w_step && w_res_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_step && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_frame_opcode  = r_out.frame_opcode;
    assign o_final_flag    = r_out.final_flag;
    assign o_frame_length  = r_out.frame_length;
    assign o_empty_frame   = r_out.empty_frame;
    assign o_last_of_frame = r_out.last_of_frame;

    `WSFD_ASSERT_SAME(a_full_input_moves, i_clk, i_rst_n, i_valid && !o_stall && r_in_vld, w_step)
    `WSFD_ASSERT_NEXT(a_result_reaches_port, i_clk, i_rst_n, w_step && w_res_vld, o_valid)
    `WSFD_ASSERT_SAME(a_empty_input_no_stall, i_clk, i_rst_n, !r_in_vld, !o_stall)

endmodule
